### design/sbhg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sbhg_pkg;

  localparam int SAMPLE_W = 16;
  localparam int ACC_W    = 32;
  localparam int COEF_W   = 32;
  localparam int PROD_W   = 2 * COEF_W;
  localparam int VOL_W    = 7;
  localparam int GAIN_W   = 12;
  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 32;
  localparam int IDX_W    = 2;

  // Register indexes on the configuration port.
  localparam logic [IDX_W-1:0] REG_FILTER_ENABLE = 2'd0;
  localparam logic [IDX_W-1:0] REG_VOLUME        = 2'd1;
  localparam logic [IDX_W-1:0] REG_MONO_MODE     = 2'd2;

  localparam logic [VOL_W-1:0] VOLUME_MAX   = 7'd99;
  localparam logic [VOL_W-1:0] VOLUME_RESET = 7'd99;
  localparam int               GAIN_MUL     = 30;
  localparam int               GAIN_SHIFT   = 10;

  // Q28 biquad coefficients.
  localparam logic signed [COEF_W-1:0] COEF_A1 = 32'sd511639552;
  localparam logic signed [COEF_W-1:0] COEF_A2 = -32'sd244645887;
  localparam logic signed [COEF_W-1:0] COEF_B0 = 32'sd248905728;
  localparam logic signed [COEF_W-1:0] COEF_B1 = -32'sd497811968;
  localparam logic signed [COEF_W-1:0] COEF_B2 = 32'sd248905945;

  localparam int A_SHIFT = 28;
  localparam int B_SHIFT = 12;
  localparam int Y_SHIFT = 16;

  localparam logic signed [ACC_W-1:0]    SAT_MAX_W = 32'sd32767;
  localparam logic signed [ACC_W-1:0]    SAT_MIN_W = -32'sd32767;
  localparam logic signed [SAMPLE_W-1:0] SAT_MAX   = 16'sd32767;
  localparam logic signed [SAMPLE_W-1:0] SAT_MIN   = -16'sd32767;

  typedef struct packed {
    logic              filter_enable;
    logic [VOL_W-1:0]  volume;
    logic              mono_mode;
    logic [GAIN_W-1:0] gain;
  } cfg_t;

  // One side's filter history, as kept in the state memory.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] x1;
    logic signed [SAMPLE_W-1:0] x2;
    logic [ACC_W-1:0]           y1;
    logic [ACC_W-1:0]           y2;
  } bq_state_t;

endpackage

`default_nettype wire

### design/sbhg_stream_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface sbhg_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [sbhg_pkg::SAMPLE_W-1:0] sample;
  logic                                side;

  modport source (output valid, output sample, output side, input ready);
  modport sink (input valid, input sample, input side, output ready);
endinterface

interface sbhg_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [sbhg_pkg::SAMPLE_W-1:0] out_sample;
  logic                                out_side;

  modport source (output valid, output out_sample, output out_side, input ready);
  modport sink (input valid, input out_sample, input out_side, output ready);
endinterface

`default_nettype wire

### design/sbhg_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module sbhg_regs (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [sbhg_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [sbhg_pkg::DATA_W-1:0]   pwdata,
  output logic      [sbhg_pkg::DATA_W-1:0]   prdata,
  output logic                               pready,
  output sbhg_pkg::cfg_t                     cfg
);
  import sbhg_pkg::*;

  logic [IDX_W-1:0] reg_idx;
  logic             wr_en;
  logic [VOL_W-1:0] vol_wr;
  logic [VOL_W-1:0] vol_sat;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && pready;
  assign vol_wr  = pwdata[VOL_W-1:0];
  assign vol_sat = (vol_wr > VOLUME_MAX) ? VOLUME_MAX : vol_wr;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.filter_enable <= 1'b0;
      cfg.volume        <= VOLUME_RESET;
      cfg.mono_mode     <= 1'b0;
      cfg.gain          <= GAIN_W'(int'(VOLUME_RESET) * GAIN_MUL);
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_FILTER_ENABLE: cfg.filter_enable <= pwdata[0];
        REG_VOLUME: begin
          cfg.volume <= vol_sat;
          cfg.gain   <= GAIN_W'(int'(vol_sat) * GAIN_MUL);
        end
        REG_MONO_MODE: cfg.mono_mode <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_FILTER_ENABLE: prdata = {{(DATA_W-1){1'b0}}, cfg.filter_enable};
      REG_VOLUME:        prdata = {{(DATA_W-VOL_W){1'b0}}, cfg.volume};
      REG_MONO_MODE:     prdata = {{(DATA_W-1){1'b0}}, cfg.mono_mode};
      default:           prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

### design/stereo_biquad_highpass_gain.sv
`timescale 1ns / 1ps
`default_nettype none

// Stereo high-pass biquad with a volume stage.
// Samples arrive on the audio channel tagged left or right and leave on the result
// channel with the same tag. Each side keeps its own direct-form-I history in a
// two-entry state memory that is read when a sample is accepted and written back
// once the five filter taps have been accumulated.
// One 32x32 multiplier does all the multiplies: five filter products, then one gain
// product. With the filter enabled an item goes through acceptance, memory read, five
// multiply/accumulate pairs, write-back, gain multiply, scaling and output load; its
// result becomes valid in the same cycle in which the block is ready again. With the
// filter bypassed an item goes from acceptance straight to the gain multiply.
// In mono mode right samples still update the right history when the filter is on, but
// produce no transaction on the result channel.
// The result sits in an output register; the block takes the next sample while it
// waits, and holds in its last step only if the previous result is still not taken.
// Reset restores the registers (volume 99, filter off, stereo) and marks both
// histories unwritten, which read as zero; the block is ready once reset is released.
// Configuration writes go through the APB-style port while the block is idle; the user
// must keep to this, as the block itself does not enforce it.

module stereo_biquad_highpass_gain (
  input  wire logic                        clk,
  input  wire logic                        rst,
  sbhg_in_if.sink                          audio,
  sbhg_out_if.source                       result,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [sbhg_pkg::ADDR_W-1:0] paddr,
  input  wire logic [sbhg_pkg::DATA_W-1:0] pwdata,
  output logic      [sbhg_pkg::DATA_W-1:0] prdata,
  output logic                             pready
);
  import sbhg_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_ACC,
    ST_STORE,
    ST_GMUL,
    ST_GAIN,
    ST_EMIT
  } state_t;

  localparam logic [2:0] LAST_STEP    = 3'd4;
  localparam logic [2:0] FIRST_X_STEP = 3'd2;
  localparam logic signed [ACC_W-1:0] GAIN_BIAS = ACC_W'((1 << GAIN_SHIFT) - 1);

  cfg_t cfg;

  state_t                     state;
  logic [2:0]                 step;
  logic                       cur_side;
  logic signed [SAMPLE_W-1:0] cur_sample;
  logic signed [SAMPLE_W-1:0] s_val;
  logic signed [SAMPLE_W-1:0] res_sample;
  bq_state_t                  hist;
  logic [ACC_W-1:0]           acc;
  logic [1:0]                 vld;

  bq_state_t                  mem [2];
  bq_state_t                  rd_entry;
  logic                       rd_vld;
  bq_state_t                  wr_entry;

  logic signed [COEF_W-1:0]   mul_a;
  logic signed [COEF_W-1:0]   mul_b;
  logic signed [PROD_W-1:0]   prod;
  logic [ACC_W-1:0]           term;
  logic signed [ACC_W-1:0]    p32;
  logic signed [ACC_W-1:0]    biased;
  logic signed [ACC_W-1:0]    scaled;
  logic signed [SAMPLE_W-1:0] sat_val;

  logic                       out_valid;
  logic signed [SAMPLE_W-1:0] out_sample;
  logic                       out_side;

  sbhg_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign audio.ready       = (state == ST_IDLE);
  assign result.valid      = out_valid;
  assign result.out_sample = out_sample;
  assign result.out_side   = out_side;

  // Shared multiplier operands.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state == ST_GMUL) begin
      mul_a = {{(COEF_W-SAMPLE_W){s_val[SAMPLE_W-1]}}, s_val};
      mul_b = {{(COEF_W-GAIN_W){1'b0}}, cfg.gain};
    end else begin
      case (step)
        3'd0: begin
          mul_a = hist.y1;
          mul_b = COEF_A1;
        end
        3'd1: begin
          mul_a = hist.y2;
          mul_b = COEF_A2;
        end
        3'd2: begin
          mul_a = {{(COEF_W-SAMPLE_W){cur_sample[SAMPLE_W-1]}}, cur_sample};
          mul_b = COEF_B0;
        end
        3'd3: begin
          mul_a = {{(COEF_W-SAMPLE_W){hist.x1[SAMPLE_W-1]}}, hist.x1};
          mul_b = COEF_B1;
        end
        3'd4: begin
          mul_a = {{(COEF_W-SAMPLE_W){hist.x2[SAMPLE_W-1]}}, hist.x2};
          mul_b = COEF_B2;
        end
        default: begin
          mul_a = '0;
          mul_b = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // Feedback terms drop 28 bits, feedforward terms 12; only the low word is summed.
  assign term = (step < FIRST_X_STEP) ? prod[A_SHIFT+ACC_W-1:A_SHIFT]
                                      : prod[B_SHIFT+ACC_W-1:B_SHIFT];

  // Division by 1024 truncates toward zero, so negative products get a bias first.
  assign p32    = prod[ACC_W-1:0];
  assign biased = p32 + (p32[ACC_W-1] ? GAIN_BIAS : '0);
  assign scaled = biased >>> GAIN_SHIFT;

  always_comb begin
    if (scaled >= SAT_MAX_W) begin
      sat_val = SAT_MAX;
    end else if (scaled <= SAT_MIN_W) begin
      sat_val = SAT_MIN;
    end else begin
      sat_val = scaled[SAMPLE_W-1:0];
    end
  end

  always_comb begin
    wr_entry.x1 = cur_sample;
    wr_entry.x2 = hist.x1;
    wr_entry.y1 = acc;
    wr_entry.y2 = hist.y1;
  end

  // State memory: one entry per side, registered read.
  always_ff @(posedge clk) begin
    rd_entry <= mem[audio.side];
    if (state == ST_STORE) begin
      mem[cur_side] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= '0;
      vld       <= '0;
      rd_vld    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_vld <= vld[audio.side];
      // The output step sets the flag itself, so the clear is left to the other states.
      if (result.ready && state != ST_EMIT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (audio.valid) begin
            cur_sample <= audio.sample;
            cur_side   <= audio.side;
            s_val      <= audio.sample;
            state      <= cfg.filter_enable ? ST_LOAD : ST_GMUL;
          end
        end
        ST_LOAD: begin
          // An entry never written back is read as the reset history of zero.
          hist  <= rd_vld ? rd_entry : '0;
          acc   <= '0;
          step  <= '0;
          state <= ST_MUL;
        end
        ST_MUL: begin
          state <= ST_ACC;
        end
        ST_ACC: begin
          acc <= acc + term;
          if (step == LAST_STEP) begin
            step  <= '0;
            state <= ST_STORE;
          end else begin
            step  <= step + 3'd1;
            state <= ST_MUL;
          end
        end
        ST_STORE: begin
          vld[cur_side] <= 1'b1;
          s_val         <= acc[Y_SHIFT+SAMPLE_W-1:Y_SHIFT];
          state         <= ST_GMUL;
        end
        ST_GMUL: begin
          state <= ST_GAIN;
        end
        ST_GAIN: begin
          res_sample <= sat_val;
          state      <= (cfg.mono_mode && cur_side) ? ST_IDLE : ST_EMIT;
        end
        ST_EMIT: begin
          if (!out_valid || result.ready) begin
            out_valid  <= 1'b1;
            out_sample <= res_sample;
            out_side   <= cur_side;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  ap_accept_next: assert property (@(posedge clk) disable iff (rst)
    (audio.valid && audio.ready) |=> (state == ST_LOAD || state == ST_GMUL))
    else $error("accepted sample did not start the filter or gain step");

  ap_step_range: assert property (@(posedge clk) disable iff (rst)
    (step <= LAST_STEP))
    else $error("tap counter out of range");

  ap_store_marks: assert property (@(posedge clk) disable iff (rst)
    (state == ST_STORE) |=> vld[$past(cur_side)])
    else $error("written history entry not marked valid");

  ap_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_EMIT)
    else $error("result loaded outside the output step");

  ap_mono_silent: assert property (@(posedge clk) disable iff (rst)
    (state == ST_GAIN && cfg.mono_mode && cur_side) |=> state == ST_IDLE)
    else $error("mono right sample reached the output step");

endmodule

`default_nettype wire
